FILE: design/rws_pkg.sv
// ----------------------------------------------------------------------------
// rws_pkg
// Shared types and field widths for the roulette wheel selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rws_pkg;

    localparam int MODE_W    = 2;
    localparam int SLOT_W    = 6;
    localparam int FIT_W     = 16;
    localparam int FRAC_W    = 16;
    localparam int IDX_OUT_W = 6;
    localparam int TOT_OUT_W = 22;
    localparam int CFG_W     = 7;

    localparam logic [CFG_W-1:0]     POP_COUNT_RST = CFG_W'(64);
    localparam logic [TOT_OUT_W-1:0] TOT_FIELD_MAX = '1;
    localparam logic [FIT_W-1:0]     FIT_ALL_ONES  = '1;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_SELECT = 2'd1,
        MODE_STATS  = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_SELECT,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: design/rws_if.sv
// ----------------------------------------------------------------------------
// rws_if
// Valid/ready channels for request and result transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rws_in_if;
    logic                        valid;
    logic                        ready;
    logic [rws_pkg::MODE_W-1:0]  mode;
    logic [rws_pkg::SLOT_W-1:0]  slot;
    logic [rws_pkg::FIT_W-1:0]   fitness;
    logic [rws_pkg::FRAC_W-1:0]  rand_fraction;

    modport source (output valid, mode, slot, fitness, rand_fraction, input ready);
    modport sink   (input valid, mode, slot, fitness, rand_fraction, output ready);
endinterface

interface rws_out_if;
    logic                           valid;
    logic                           ready;
    logic [rws_pkg::IDX_OUT_W-1:0]  selected_index;
    logic [rws_pkg::TOT_OUT_W-1:0]  total_fitness;
    logic [rws_pkg::FIT_W-1:0]      best_fitness;
    logic [rws_pkg::FIT_W-1:0]      worst_fitness;
    logic [rws_pkg::FIT_W-1:0]      average_fitness;
    logic [rws_pkg::IDX_OUT_W-1:0]  fittest_index;

    modport source (output valid, selected_index, total_fitness, best_fitness,
                    worst_fitness, average_fitness, fittest_index, input ready);
    modport sink   (input valid, selected_index, total_fitness, best_fitness,
                    worst_fitness, average_fitness, fittest_index, output ready);
endinterface

`default_nettype wire

FILE: design/roulette_wheel_selector_core.sv
// ----------------------------------------------------------------------------
// roulette_wheel_selector_core
// Fitness table with load, statistics scan and roulette selection.
//
// One request transaction is handled at a time; every request yields exactly
// one result transaction carrying the current statistics. A selection walks
// the table through its single read port, one entry a cycle, and stops at the
// chosen index. A statistics scan reads all n active entries and then runs a
// bit-serial divider for the average, one quotient bit a cycle. After reset
// the table is cleared by a pass over all POP_MAX entries during which no
// request is taken; the population count register may be written at any
// time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module roulette_wheel_selector_core #(
    parameter int POP_MAX = 64
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire  [rws_pkg::CFG_W-1:0]    i_cfg_wdata,
    rws_in_if.sink                       i_in,
    rws_out_if.source                    o_out
);
    import rws_pkg::*;

    localparam int IDX_W  = (POP_MAX > 1) ? $clog2(POP_MAX) : 1;
    localparam int CNT_W  = $clog2(POP_MAX + 1);
    localparam int TOT_W  = FIT_W + CNT_W;
    localparam int PROD_W = FRAC_W + TOT_W;
    localparam int DC_W   = $clog2(TOT_W);

    // table memory
    logic [FIT_W-1:0] m_table [POP_MAX];
    logic [FIT_W-1:0] r_rdata;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [FIT_W-1:0] mem_wdata;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_clr_idx, n_clr_idx;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [IDX_W-1:0]   r_last, n_last;
    logic [IDX_W-1:0]   r_rd_idx, n_rd_idx;
    logic               r_rd_on, n_rd_on;
    logic               r_dat_vld, n_dat_vld;
    logic [IDX_W-1:0]   r_dat_idx, n_dat_idx;
    logic [PROD_W-1:0]  r_target, n_target;
    logic [TOT_W-1:0]   r_run, n_run;
    logic [TOT_W-1:0]   r_sum, n_sum;
    logic [FIT_W-1:0]   r_best, n_best;
    logic [FIT_W-1:0]   r_worst, n_worst;
    logic [FIT_W-1:0]   r_mean, n_mean;
    logic [IDX_W-1:0]   r_best_idx, n_best_idx;
    logic [IDX_W-1:0]   r_sel, n_sel;
    logic [CNT_W-1:0]   r_rem, n_rem;
    logic [TOT_W-1:0]   r_quo, n_quo;
    logic [DC_W-1:0]    r_div_cnt, n_div_cnt;
    logic [CFG_W-1:0]   r_pop_count;
    logic               r_out_valid, n_out_valid;
    logic               out_load;

    logic [IDX_OUT_W-1:0] r_o_sel;
    logic [TOT_OUT_W-1:0] r_o_total;
    logic [FIT_W-1:0]     r_o_best;
    logic [FIT_W-1:0]     r_o_worst;
    logic [FIT_W-1:0]     r_o_mean;
    logic [IDX_OUT_W-1:0] r_o_best_idx;

    logic               in_acc;
    logic [31:0]        cnt_ext;
    logic [CNT_W-1:0]   act_n;
    logic [PROD_W-1:0]  mul_prod;
    logic [TOT_W-1:0]   run_next;
    logic [TOT_W-1:0]   sum_next;
    logic               hit;
    logic               is_last;
    logic [CNT_W:0]     rem_sh;
    logic               q_bit;
    logic [TOT_W-1:0]   quo_next;
    logic [TOT_OUT_W-1:0] tot_sat;

    assign in_acc     = i_in.valid & i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    // a count of zero acts as one, above the table size as the table size
    assign cnt_ext = 32'(r_pop_count);
    assign act_n   = (cnt_ext == 32'd0) ? CNT_W'(1) :
                     (cnt_ext > 32'(POP_MAX)) ? CNT_W'(POP_MAX) : CNT_W'(cnt_ext);

    assign mul_prod = PROD_W'(i_in.rand_fraction) * PROD_W'(r_sum);
    assign run_next = r_run + TOT_W'(r_rdata);
    assign sum_next = r_sum + TOT_W'(r_rdata);
    assign hit      = ({run_next, {FRAC_W{1'b0}}} >= r_target);
    assign is_last  = (r_dat_idx == r_last);

    // restoring divider step
    assign rem_sh   = {r_rem, r_quo[TOT_W-1]};
    assign q_bit    = (rem_sh >= {1'b0, r_n});
    assign quo_next = {r_quo[TOT_W-2:0], q_bit};

    assign tot_sat = (32'(r_sum) > 32'(TOT_FIELD_MAX)) ? TOT_FIELD_MAX : TOT_OUT_W'(r_sum);

    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_n         = r_n;
        n_last      = r_last;
        n_rd_idx    = r_rd_idx;
        n_rd_on     = r_rd_on;
        n_dat_vld   = r_rd_on;
        n_dat_idx   = r_rd_idx;
        n_target    = r_target;
        n_run       = r_run;
        n_sum       = r_sum;
        n_best      = r_best;
        n_worst     = r_worst;
        n_mean      = r_mean;
        n_best_idx  = r_best_idx;
        n_sel       = r_sel;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_div_cnt   = r_div_cnt;
        n_out_valid = r_out_valid & ~o_out.ready;
        out_load    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_clr_idx;
        mem_wdata   = '0;

        if (r_rd_on) begin
            n_rd_idx = r_rd_idx + IDX_W'(1);
            if (r_rd_idx == r_last) begin
                n_rd_on = 1'b0;
            end
        end

        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                n_clr_idx = r_clr_idx + IDX_W'(1);
                if (r_clr_idx == IDX_W'(POP_MAX - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_sel  = '0;
                    n_n    = act_n;
                    n_last = IDX_W'(act_n - CNT_W'(1));
                    unique case (t_mode'(i_in.mode))
                        MODE_LOAD: begin
                            if (32'(i_in.slot) < 32'(POP_MAX)) begin
                                mem_we = 1'b1;
                            end
                            mem_waddr = IDX_W'(i_in.slot);
                            mem_wdata = i_in.fitness;
                            n_state   = ST_DONE;
                        end
                        MODE_SELECT: begin
                            n_target = mul_prod;
                            n_run    = '0;
                            n_rd_idx = '0;
                            n_rd_on  = 1'b1;
                            n_state  = ST_SELECT;
                        end
                        MODE_STATS: begin
                            n_sum    = '0;
                            n_best   = '0;
                            n_worst  = FIT_ALL_ONES;
                            n_rd_idx = '0;
                            n_rd_on  = 1'b1;
                            n_state  = ST_SCAN;
                        end
                        MODE_NONE: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_dat_vld) begin
                    n_sum = sum_next;
                    if (r_rdata > r_best) begin
                        n_best     = r_rdata;
                        n_best_idx = r_dat_idx;
                    end
                    if (r_rdata < r_worst) begin
                        n_worst = r_rdata;
                    end
                    if (is_last) begin
                        n_rem     = '0;
                        n_quo     = sum_next;
                        n_div_cnt = DC_W'(TOT_W - 1);
                        n_state   = ST_DIV;
                    end
                end
            end
            ST_SELECT: begin
                if (r_dat_vld) begin
                    n_run = run_next;
                    if (hit || is_last) begin
                        n_sel     = r_dat_idx;
                        n_rd_on   = 1'b0;
                        n_dat_vld = 1'b0;
                        n_state   = ST_DONE;
                    end
                end
            end
            ST_DIV: begin
                n_rem     = q_bit ? CNT_W'(rem_sh - {1'b0, r_n}) : CNT_W'(rem_sh);
                n_quo     = quo_next;
                n_div_cnt = r_div_cnt - DC_W'(1);
                if (r_div_cnt == '0) begin
                    // average never exceeds the largest entry, so 16 bits hold it
                    n_mean  = quo_next[FIT_W-1:0];
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_rd_on     <= 1'b0;
            r_dat_vld   <= 1'b0;
            r_sum       <= '0;
            r_best      <= '0;
            r_worst     <= FIT_ALL_ONES;
            r_mean      <= '0;
            r_best_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_rd_on     <= n_rd_on;
            r_dat_vld   <= n_dat_vld;
            r_sum       <= n_sum;
            r_best      <= n_best;
            r_worst     <= n_worst;
            r_mean      <= n_mean;
            r_best_idx  <= n_best_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_last    <= n_last;
        r_rd_idx  <= n_rd_idx;
        r_dat_idx <= n_dat_idx;
        r_target  <= n_target;
        r_run     <= n_run;
        r_sel     <= n_sel;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_div_cnt <= n_div_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pop_count <= POP_COUNT_RST;
        end else if (i_cfg_we) begin
            r_pop_count <= i_cfg_wdata;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_sel      <= IDX_OUT_W'(r_sel);
            r_o_total    <= tot_sat;
            r_o_best     <= r_best;
            r_o_worst    <= r_worst;
            r_o_mean     <= r_mean;
            r_o_best_idx <= IDX_OUT_W'(r_best_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            m_table[mem_waddr] <= mem_wdata;
        end
        r_rdata <= m_table[r_rd_idx];
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.selected_index  = r_o_sel;
    assign o_out.total_fitness   = r_o_total;
    assign o_out.best_fitness    = r_o_best;
    assign o_out.worst_fitness   = r_o_worst;
    assign o_out.average_fitness = r_o_mean;
    assign o_out.fittest_index   = r_o_best_idx;

    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !i_in.ready)
        else $error("request taken during table clear");

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_on |-> (r_rd_idx <= r_last))
        else $error("table read beyond active population");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_n))
        else $error("divider remainder not below divisor");

    a_sel_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SELECT && n_state == ST_DONE) |=> (r_sel <= r_last))
        else $error("selected index beyond active population");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result raised outside completion state");

endmodule

`default_nettype wire
